// ===== design/snd_pkg.sv =====
package snd_pkg;

    localparam int NONCE_W = 64;
    localparam int MSG_WORDS = 5;
    localparam int DIGITS_MAX = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_WORD_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_WORD_4 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIFFICULTY = 3'd6;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;

    typedef logic [31:0] word_t;

    // Decimal text of one nonce, most significant digit in digit_text[0].
    typedef struct packed {
        logic [NONCE_W-1:0] nonce;
        logic [4:0] ndigits;
        logic [DIGITS_MAX-1:0][7:0] digit_text;
    } job_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_ROUND,
        BK_ADD,
        BK_COUNT,
        BK_DONE
    } back_state_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== design/snd_front.sv =====
// Front end: accepts a nonce and converts it to decimal text by shift-and-add-3,
// one nonce bit a cycle.
module snd_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [63:0]     s_nonce,
    output logic            job_valid,
    input  logic            job_ready,
    output snd_pkg::job_t   job
);
    import snd_pkg::*;

    front_state_t state_reg, state_next;
    logic [NONCE_W-1:0] shift_reg, shift_next;
    logic [NONCE_W-1:0] nonce_reg, nonce_next;
    logic [DIGITS_MAX-1:0][3:0] bcd_reg, bcd_next;
    logic [5:0] bit_reg, bit_next;
    logic [DIGITS_MAX-1:0][3:0] bcd_adj;
    logic [4:0] nd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        shift_reg <= shift_next;
        nonce_reg <= nonce_next;
        bcd_reg <= bcd_next;
        bit_reg <= bit_next;
    end

    // Any decimal digit of five or more is bumped by three before the shift, so that
    // it carries correctly into the next digit.
    always_comb begin
        for (int i = 0; i < DIGITS_MAX; i++) begin
            if (bcd_reg[i] >= 4'd5) begin
                bcd_adj[i] = bcd_reg[i] + 4'd3;
            end else begin
                bcd_adj[i] = bcd_reg[i];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        shift_next = shift_reg;
        nonce_next = nonce_reg;
        bcd_next = bcd_reg;
        bit_next = bit_reg;
        s_ready = 1'b0;
        job_valid = 1'b0;
        case (state_reg)
            FR_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    shift_next = s_nonce;
                    nonce_next = s_nonce;
                    bcd_next = '0;
                    bit_next = 6'd0;
                    state_next = FR_CONV;
                end
            end
            FR_CONV: begin
                bcd_next = {bcd_adj[DIGITS_MAX-1][2:0], bcd_adj[DIGITS_MAX-2:0],
                            shift_reg[NONCE_W-1]};
                shift_next = {shift_reg[NONCE_W-2:0], 1'b0};
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd63) begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                job_valid = 1'b1;
                if (job_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    // Digit count ignores leading zeros but always keeps the units digit.
    always_comb begin
        nd = 5'd1;
        for (int i = 1; i < DIGITS_MAX; i++) begin
            if (bcd_reg[i] != 4'd0) nd = 5'(i + 1);
        end
    end

    always_comb begin
        job.nonce = nonce_reg;
        job.ndigits = nd;
        for (int i = 0; i < DIGITS_MAX; i++) begin
            if (i < 32'(nd)) begin
                job.digit_text[i] = DIGIT_ZERO | {4'd0, bcd_reg[5'(32'(nd) - 1 - i)]};
            end else begin
                job.digit_text[i] = 8'd0;
            end
        end
    end

endmodule

// ===== design/snd_queue.sv =====
// Two-entry queue between the digit converter and the hash engine.
module snd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  snd_pkg::job_t   in_job,
    output logic            out_valid,
    input  logic            out_ready,
    output snd_pkg::job_t   out_job
);
    import snd_pkg::*;

    job_t slot_reg [2];
    logic wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_job = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
        if (push) slot_reg[wr_reg] <= in_job;
    end

endmodule

// ===== design/snd_back.sv =====
// Back end: builds the padded blocks, runs one SHA-256 round a cycle and
// counts leading zero nibbles one a cycle.
module snd_back #(
    parameter int MESSAGE_MAX_BYTES = 40
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  snd_pkg::job_t   job,
    input  logic [5:0]      message_length,
    input  logic [snd_pkg::MSG_WORDS-1:0][63:0] message_words,
    input  logic [6:0]      difficulty,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_found,
    output logic [63:0]     m_nonce_echo,
    output logic [63:0]     m_digest_high,
    output logic [6:0]      m_zero_nibbles
);
    import snd_pkg::*;

    back_state_t state_reg, state_next;
    job_t job_reg, job_next;
    logic [6:0] len_reg, len_next;
    logic blk_reg, blk_next, two_reg, two_next;
    logic [5:0] rnd_reg, rnd_next;
    word_t w_reg [16];
    word_t w_next [16];
    word_t a_reg[8];
    word_t a_next[8];
    word_t h_reg[8];
    word_t h_next[8];
    logic [6:0] zc_reg, zc_next;
    logic [7:0] buf_bytes [128];
    logic [6:0] total;
    logic [63:0] bitlen;
    logic [6:0] eff_len;
    word_t s1, ch, t1, s0, mj, ws0, ws1, wnew;
    logic out_v_reg, out_v_next;
    logic [3:0] nib;

    assign eff_len = (message_length > 6'(MESSAGE_MAX_BYTES)) ?
                     7'(MESSAGE_MAX_BYTES) : {1'b0, message_length};
    assign total = len_reg + {2'd0, job_reg.ndigits};
    assign bitlen = {54'd0, total, 3'd0};

    // Message assembly: each byte picks its source independently.
    always_comb begin
        for (int i = 0; i < 128; i++) begin
            buf_bytes[i] = 8'd0;
            if (i < 32'(len_reg)) begin
                if (i < 40) buf_bytes[i] = message_words[i/8][8*(7-(i%8)) +: 8];
            end else if (i < 32'(total)) begin
                buf_bytes[i] = job_reg.digit_text[5'(i - 32'(len_reg))];
            end else if (i == 32'(total)) begin
                buf_bytes[i] = 8'h80;
            end
            if (two_reg && i >= 120) buf_bytes[i] = bitlen[8*(127-i) +: 8];
            if (!two_reg && i >= 56 && i < 64) buf_bytes[i] = bitlen[8*(63-i) +: 8];
        end
    end

    assign s1 = rotr(a_reg[4], 6) ^ rotr(a_reg[4], 11) ^ rotr(a_reg[4], 25);
    assign ch = (a_reg[4] & a_reg[5]) ^ (~a_reg[4] & a_reg[6]);
    assign t1 = a_reg[7] + s1 + ch + round_k(rnd_reg) + w_reg[0];
    assign s0 = rotr(a_reg[0], 2) ^ rotr(a_reg[0], 13) ^ rotr(a_reg[0], 22);
    assign mj = (a_reg[0] & a_reg[1]) ^ (a_reg[0] & a_reg[2]) ^ (a_reg[1] & a_reg[2]);
    assign ws0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign ws1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + ws0 + w_reg[9] + ws1;
    assign nib = h_reg[zc_reg[5:3]][4*(7-zc_reg[2:0]) +: 4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
        job_reg <= job_next;
        len_reg <= len_next;
        blk_reg <= blk_next;
        two_reg <= two_next;
        rnd_reg <= rnd_next;
        w_reg <= w_next;
        a_reg <= a_next;
        h_reg <= h_next;
        zc_reg <= zc_next;
    end

    always_comb begin
        state_next = state_reg;
        job_next = job_reg;
        len_next = len_reg;
        blk_next = blk_reg;
        two_next = two_reg;
        rnd_next = rnd_reg;
        w_next = w_reg;
        a_next = a_reg;
        h_next = h_reg;
        zc_next = zc_reg;
        out_v_next = out_v_reg;
        job_ready = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) begin
                    job_next = job;
                    len_next = eff_len;
                    two_next = (eff_len + {2'd0, job.ndigits} + 7'd9) > 7'd64;
                    blk_next = 1'b0;
                    for (int i = 0; i < 8; i++) h_next[i] = init_h(3'(i));
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD: begin
                for (int i = 0; i < 16; i++) begin
                    w_next[i] = {buf_bytes[64*blk_reg + 4*i], buf_bytes[64*blk_reg + 4*i + 1],
                                 buf_bytes[64*blk_reg + 4*i + 2],
                                 buf_bytes[64*blk_reg + 4*i + 3]};
                end
                a_next = h_reg;
                rnd_next = 6'd0;
                state_next = BK_ROUND;
            end
            BK_ROUND: begin
                a_next[7] = a_reg[6]; a_next[6] = a_reg[5]; a_next[5] = a_reg[4];
                a_next[4] = a_reg[3] + t1;
                a_next[3] = a_reg[2]; a_next[2] = a_reg[1]; a_next[1] = a_reg[0];
                a_next[0] = t1 + s0 + mj;
                for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
                w_next[15] = wnew;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) state_next = BK_ADD;
            end
            BK_ADD: begin
                for (int i = 0; i < 8; i++) h_next[i] = h_reg[i] + a_reg[i];
                if (two_reg && !blk_reg) begin
                    blk_next = 1'b1;
                    state_next = BK_LOAD;
                end else begin
                    zc_next = 7'd0;
                    state_next = BK_COUNT;
                end
            end
            BK_COUNT: begin
                if (zc_reg == 7'd64 || nib != 4'd0) begin
                    out_v_next = 1'b1;
                    state_next = BK_DONE;
                end else begin
                    zc_next = zc_reg + 7'd1;
                end
            end
            BK_DONE: begin
                if (m_ready) begin
                    out_v_next = 1'b0;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign m_valid = out_v_reg;
    assign m_found = zc_reg >= difficulty;
    assign m_nonce_echo = job_reg.nonce;
    assign m_digest_high = {h_reg[0], h_reg[1]};
    assign m_zero_nibbles = zc_reg;

endmodule

// ===== design/sha256_nonce_difficulty_check.sv =====
// SHA-256 proof-of-work nonce checker. Each request carries a nonce; its decimal
// text is appended to the configured message, hashed, and the result reports the
// leading zero hex digits of the digest against the difficulty. The front end
// accepts a request, runs shift-and-add-3 decimal conversion and hands the text
// over; the back end accepts it, then per 64-byte block loads the block, runs one
// round per cycle and does the final add, then counts leading zero nibbles up to
// the first non-zero one and hands the result over. Neither end takes a new nonce
// before it is through with the last. A two-entry queue lets the two ends overlap,
// so the back end sets the sustained rate, which drops when the text needs two
// blocks and as the leading zero count grows.
// Configuration must only be written while no request is in flight.
module sha256_nonce_difficulty_check #(
    parameter int MESSAGE_MAX_BYTES = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_nonce,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [63:0] m_nonce_echo,
    output logic [63:0] m_digest_high,
    output logic [6:0]  m_zero_nibbles
);
    import snd_pkg::*;

    logic [5:0] msg_len_reg;
    logic [MSG_WORDS-1:0][63:0] msg_word_reg;
    logic [6:0] difficulty_reg;
    job_t f_job, b_job;
    logic f_valid, f_ready, b_valid, b_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_len_reg <= '0;
            msg_word_reg <= '0;
            difficulty_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == REG_MESSAGE_LENGTH) msg_len_reg <= cfg_data[5:0];
            else if (cfg_index == REG_DIFFICULTY) difficulty_reg <= cfg_data[6:0];
            else if (cfg_index >= REG_MESSAGE_WORD_0 && cfg_index <= REG_MESSAGE_WORD_4)
                msg_word_reg[cfg_index - REG_MESSAGE_WORD_0] <= cfg_data;
        end
    end

    snd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_nonce(s_nonce),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    snd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
        .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
    );

    snd_back #(.MESSAGE_MAX_BYTES(MESSAGE_MAX_BYTES)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .message_length(msg_len_reg), .message_words(msg_word_reg),
        .difficulty(difficulty_reg),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found),
        .m_nonce_echo(m_nonce_echo), .m_digest_high(m_digest_high),
        .m_zero_nibbles(m_zero_nibbles)
    );

endmodule

// ===== design/snd_checker.sv =====
module snd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [63:0] s_nonce,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic [63:0] m_nonce_echo,
    input logic [63:0] m_digest_high,
    input logic [6:0]  m_zero_nibbles
);
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_nonce))
        else $error("request withdrawn while waiting");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_nonce_echo) && $stable(m_found))
        else $error("result dropped while stalled");
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_zero_nibbles <= 7'd64)
        else $error("zero count out of range");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_nibbles >= 7'd16 |-> m_digest_high == 64'd0)
        else $error("zero count disagrees with digest");
endmodule

bind sha256_nonce_difficulty_check snd_checker u_checker (.*);

// ===== test/tb_sha256_nonce_difficulty_check.sv =====
module tb_sha256_nonce_difficulty_check;
    import snd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [63:0] NONCE_MAX = 64'hffff_ffff_ffff_ffff;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic        found;
        logic [63:0] nonce_echo;
        logic [63:0] digest_high;
        logic [6:0]  zero_nibbles;
    } check_result_t;

    class nonce_scoreboard;
        logic [5:0]  msg_len;
        logic [63:0] msg_words [MSG_WORDS];
        logic [6:0]  required_zeros;
        check_result_t pending_results [$];
        int mismatches;

        function new();
            msg_len = '0;
            required_zeros = '0;
            foreach (msg_words[i]) msg_words[i] = '0;
            mismatches = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
            if (idx == REG_MESSAGE_LENGTH)
                msg_len = value[5:0];
            else if (idx >= REG_MESSAGE_WORD_0 && idx <= REG_MESSAGE_WORD_4)
                msg_words[idx - REG_MESSAGE_WORD_0] = value;
            else if (idx == REG_DIFFICULTY)
                required_zeros = value[6:0];
        endfunction

        static function logic [31:0] ror32(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        static function logic [255:0] compress_block(logic [255:0] st, logic [511:0] blk);
            logic [31:0] w [64];
            logic [31:0] a, b, c, d, e, f, g, hh, s0, s1, t1, t2;
            for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
            for (int i = 16; i < 64; i++) begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            {a, b, c, d, e, f, g, hh} = st;
            for (int i = 0; i < 64; i++) begin
                t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                     + SHA_K[i] + w[i];
                t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            return {st[255:224] + a, st[223:192] + b, st[191:160] + c, st[159:128] + d,
                    st[127:96] + e, st[95:64] + f, st[63:32] + g, st[31:0] + hh};
        endfunction

        // Hashes message plus decimal nonce text and works out the whole result.
        function check_result_t hash_nonce(logic [63:0] nonce);
            logic [7:0]   text [128];
            logic [7:0]   digits [20];
            logic [63:0]  v;
            logic [511:0] blk;
            logic [255:0] st;
            logic [63:0]  bit_len;
            int len, nd, total, nblocks, zeros;
            check_result_t r;
            foreach (text[i]) text[i] = '0;
            len = (msg_len > 40) ? 40 : msg_len;
            for (int i = 0; i < len; i++) text[i] = msg_words[i / 8][63 - 8 * (i % 8) -: 8];
            v = nonce;
            nd = 0;
            do begin
                digits[nd] = DIGIT_ZERO + 8'(v % 10);
                v = v / 10;
                nd++;
            end while (v != 0 && nd < 20);
            for (int i = 0; i < nd; i++) text[len + i] = digits[nd - 1 - i];
            total = len + nd;
            text[total] = 8'h80;
            nblocks = (total + 9 <= 64) ? 1 : 2;
            bit_len = 64'(total) * 8;
            for (int i = 0; i < 8; i++) text[nblocks * 64 - 1 - i] = bit_len[8 * i +: 8];
            st = SHA_IV;
            for (int bk = 0; bk < nblocks; bk++) begin
                for (int j = 0; j < 64; j++) blk[511 - 8 * j -: 8] = text[64 * bk + j];
                st = compress_block(st, blk);
            end
            zeros = 0;
            while (zeros < 64 && st[255 - 4 * zeros -: 4] == 4'h0) zeros++;
            r.found = (zeros >= required_zeros);
            r.nonce_echo = nonce;
            r.digest_high = st[255:192];
            r.zero_nibbles = 7'(zeros);
            return r;
        endfunction

        function void note_request(logic [63:0] nonce);
            pending_results.push_back(hash_nonce(nonce));
        endfunction

        function void check_result(check_result_t got);
            check_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result for nonce %0d", got.nonce_echo);
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.nonce_echo !== want.nonce_echo
                || got.digest_high !== want.digest_high
                || got.zero_nibbles !== want.zero_nibbles) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected found=%0d nonce=%0d digest=%h zeros=%0d, got found=%0d nonce=%0d digest=%h zeros=%0d",
                             want.found, want.nonce_echo, want.digest_high, want.zero_nibbles,
                             got.found, got.nonce_echo, got.digest_high, got.zero_nibbles);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_nonce = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [63:0] m_nonce_echo;
    logic [63:0] m_digest_high;
    logic [6:0]  m_zero_nibbles;

    nonce_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 1'b0;

    sha256_nonce_difficulty_check DUT (.*);

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_found, m_nonce_echo, m_digest_high, m_zero_nibbles});
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.write_register(idx, value);
        @(posedge aclk);
    endtask

    // The last request has just been taken, so valid is dropped before the block
    // can ask for another one.
    task automatic set_config(logic [63:0] len, logic [63:0] diff, bit ones_words);
        s_valid <= 1'b0;
        wait (sb.pending_results.size() == 0);
        repeat (20) @(posedge aclk);
        write_reg(REG_MESSAGE_LENGTH, len);
        for (int w = 0; w < MSG_WORDS; w++)
            write_reg(REG_MESSAGE_WORD_0 + 3'(w),
                      ones_words ? NONCE_MAX : {$urandom, $urandom});
        write_reg(REG_DIFFICULTY, diff);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_nonce(logic [63:0] nonce);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_nonce <= nonce;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(nonce);
    endtask

    function automatic logic [63:0] random_nonce();
        return {$urandom, $urandom} >> $urandom_range(63);
    endfunction

    initial begin
        #10_000_000;
        $display("tb_sha256_nonce_difficulty_check failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write to the spare index must leave every register untouched.
        set_config(0, 0, 0);
        write_reg(REG_UNUSED, NONCE_MAX);
        cfg_we <= 1'b0;
        push_nonce(0);
        push_nonce(9);
        push_nonce(10);
        push_nonce(NONCE_MAX);
        push_nonce(64'd10_000_000_000_000_000_000);
        push_nonce(64'h8000_0000_0000_0000);
        // Forty bytes plus 15 digits fits one block; 16 digits needs two.
        set_config(40, 64, 1);
        push_nonce(64'd100_000_000_000_000);
        push_nonce(64'd999_999_999_999_999);
        push_nonce(64'd1_000_000_000_000_000);
        push_nonce(NONCE_MAX);
        // Oversized length saturates; difficulty beyond the digest never passes.
        set_config(63, 127, 0);
        push_nonce(0);
        push_nonce(NONCE_MAX);
        set_config(41, 65, 0);
        push_nonce(12345);
        set_config(47, 1, 0);
        push_nonce(7);
        push_nonce(NONCE_MAX);

        for (int phase = 0; phase < 8; phase++) begin
            set_config(phase == 0 ? 64'd40 : 64'($urandom_range(63)),
                       64'($urandom_range(3)), 0);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (phase == 4) begin
                // Hold the result side off long enough for the queue to back up.
                fork
                    begin
                        recv_hold = 1'b1;
                        repeat (3000) @(posedge aclk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 200; k++) push_nonce(random_nonce());
        end
        s_valid <= 1'b0;

        wait (sb.pending_results.size() == 0);
        repeat (400) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb_sha256_nonce_difficulty_check passed");
        else
            $display("tb_sha256_nonce_difficulty_check failed");
        $finish;
    end

endmodule

// ===== sha256_nonce_difficulty_check.f =====
design/snd_pkg.sv
design/snd_front.sv
design/snd_queue.sv
design/snd_back.sv
design/sha256_nonce_difficulty_check.sv
design/snd_checker.sv
test/tb_sha256_nonce_difficulty_check.sv
